### rtl/irpd_pkg.sv
`default_nettype none

package irpd_pkg;

    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MARK_TICKS         = 3'd0,
        REG_ZERO_PERIOD_TICKS  = 3'd1,
        REG_ONE_PERIOD_TICKS   = 3'd2,
        REG_HEADER_MARK_TICKS  = 3'd3,
        REG_HEADER_TOTAL_TICKS = 3'd4
    } irpd_reg_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_SEND = 1'b1
    } irpd_op_t;

    localparam int RST_MARK_TICKS         = 22;
    localparam int RST_ZERO_PERIOD_TICKS  = 44;
    localparam int RST_ONE_PERIOD_TICKS   = 88;
    localparam int RST_HEADER_MARK_TICKS  = 171;
    localparam int RST_HEADER_TOTAL_TICKS = 342;

    localparam int BYTE_BITS     = 8;
    localparam int S_TDATA_BITS  = 16;
    localparam int M_TDATA_BITS  = 8;

    typedef struct packed {
        logic busy_res;
        logic led;
    } irpd_result_t;

endpackage

`default_nettype wire

### rtl/irpd_engine.sv
`default_nettype none

module irpd_engine
    import irpd_pkg::*;
#(
    parameter int WORD_BITS = 16,
    parameter int TICK_BITS = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step,
    input  wire logic                  op,
    input  wire logic [BYTE_BITS-1:0]  address,
    input  wire logic [BYTE_BITS-1:0]  command_byte,
    input  wire logic [TICK_BITS-1:0]  mark_ticks,
    input  wire logic [TICK_BITS-1:0]  zero_period_ticks,
    input  wire logic [TICK_BITS-1:0]  one_period_ticks,
    input  wire logic [TICK_BITS-1:0]  header_mark_ticks,
    input  wire logic [TICK_BITS-1:0]  header_total_ticks,
    output irpd_result_t               result_next
);

    localparam int BL_W = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] shift_word_reg, shift_word_next;
    logic [WORD_BITS-1:0] second_word_reg, second_word_next;
    logic [BL_W-1:0]      bits_left_reg, bits_left_next;
    logic [TICK_BITS-1:0] phase_ticks_reg, phase_ticks_next;
    logic                 header_pending_reg, header_pending_next;
    logic                 second_word_active_reg, second_word_active_next;
    logic                 sending_reg, sending_next;
    logic                 led_level_reg, led_level_next;

    logic [TICK_BITS-1:0] period;

    always_comb begin
        shift_word_next         = shift_word_reg;
        second_word_next        = second_word_reg;
        bits_left_next          = bits_left_reg;
        phase_ticks_next        = phase_ticks_reg;
        header_pending_next     = header_pending_reg;
        second_word_active_next = second_word_active_reg;
        sending_next            = sending_reg;
        led_level_next          = led_level_reg;
        period                  = zero_period_ticks;

        if (op == OP_SEND) begin
            sending_next        = 1'b1;
            phase_ticks_next    = TICK_BITS'(1);
            shift_word_next     = WORD_BITS'({address, address});
            second_word_next    = WORD_BITS'({command_byte, ~command_byte});
            bits_left_next      = BL_W'(WORD_BITS);
            header_pending_next = 1'b1;
        end else begin
            // bit phase, header first
            if (sending_next && bits_left_next != '0) begin
                if (header_pending_next) begin
                    if (phase_ticks_next <= header_mark_ticks) begin
                        led_level_next = ~led_level_next;
                    end else if (phase_ticks_next <= header_total_ticks) begin
                        led_level_next = 1'b0;
                    end else begin
                        phase_ticks_next    = TICK_BITS'(1);
                        header_pending_next = 1'b0;
                    end
                end
                if (!header_pending_next) begin
                    period = shift_word_next[WORD_BITS-1] ? one_period_ticks
                                                          : zero_period_ticks;
                    if (phase_ticks_next <= mark_ticks) begin
                        led_level_next = ~led_level_next;
                    end else begin
                        led_level_next = 1'b0;
                    end
                    if (phase_ticks_next >= period) begin
                        phase_ticks_next = '0;
                        shift_word_next  = shift_word_next << 1;
                        bits_left_next   = bits_left_next - BL_W'(1);
                    end
                end
                phase_ticks_next = phase_ticks_next + TICK_BITS'(1);
            end
            // word done: next word or end burst
            if (sending_next && bits_left_next == '0) begin
                if (!second_word_active_next) begin
                    shift_word_next         = second_word_next;
                    bits_left_next          = BL_W'(WORD_BITS);
                    second_word_active_next = 1'b1;
                end else begin
                    if (phase_ticks_next <= mark_ticks) begin
                        led_level_next = ~led_level_next;
                    end else begin
                        led_level_next          = 1'b0;
                        phase_ticks_next        = '0;
                        second_word_active_next = 1'b0;
                        sending_next            = 1'b0;
                    end
                    phase_ticks_next = phase_ticks_next + TICK_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_left_reg          <= '0;
            phase_ticks_reg        <= TICK_BITS'(1);
            header_pending_reg     <= 1'b0;
            second_word_active_reg <= 1'b0;
            sending_reg            <= 1'b0;
            led_level_reg          <= 1'b0;
        end else if (step) begin
            bits_left_reg          <= bits_left_next;
            phase_ticks_reg        <= phase_ticks_next;
            header_pending_reg     <= header_pending_next;
            second_word_active_reg <= second_word_active_next;
            sending_reg            <= sending_next;
            led_level_reg          <= led_level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            shift_word_reg  <= shift_word_next;
            second_word_reg <= second_word_next;
        end
    end

    assign result_next.led      = led_level_next;
    assign result_next.busy_res = sending_next;

    a_header_only_while_sending: assert property (@(posedge aclk) disable iff (!aresetn)
        header_pending_reg |-> sending_reg)
        else $error("header pending while idle");

    a_header_before_bits: assert property (@(posedge aclk) disable iff (!aresetn)
        header_pending_reg |-> bits_left_reg == BL_W'(WORD_BITS))
        else $error("bits shifted during header");

    a_bits_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_left_reg <= BL_W'(WORD_BITS))
        else $error("bit count out of range");

    a_send_starts_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        step && op == OP_SEND |=> sending_reg && header_pending_reg)
        else $error("send did not start a frame");

endmodule

`default_nettype wire

### rtl/ir_pulse_distance_transmitter.sv
`default_nettype none

// channel | direction | handshake          | payload
// s_      | in        | s_tvalid/s_tready  | tdata: address, command_byte; tuser: op
// m_      | out       | m_tvalid/m_tready  | tdata: led, busy_res
// cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one word per cycle while s_tready is high; the result is registered and appears in the cycle after its input word
// the frame state updates in a single pass, so ticks may arrive back to back
// s_tready drops only while a result waits and m_tready is low
// reset is synchronous, active low; timing registers return to defaults
// cfg_ready is always high

module ir_pulse_distance_transmitter
    import irpd_pkg::*;
#(
    parameter int WORD_BITS = 16,
    parameter int TICK_BITS = 10
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [S_TDATA_BITS-1:0]   s_tdata,   // address, command_byte
    input  wire logic                      s_tuser,   // op
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [M_TDATA_BITS-1:0]        m_tdata,   // led, busy_res, zero pad
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [TICK_BITS-1:0]      cfg_data
);

    logic [TICK_BITS-1:0] mark_ticks_reg;
    logic [TICK_BITS-1:0] zero_period_ticks_reg;
    logic [TICK_BITS-1:0] one_period_ticks_reg;
    logic [TICK_BITS-1:0] header_mark_ticks_reg;
    logic [TICK_BITS-1:0] header_total_ticks_reg;

    logic         m_tvalid_reg;
    irpd_result_t result_reg;
    irpd_result_t result_next;
    logic         s_accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_ticks_reg         <= TICK_BITS'(RST_MARK_TICKS);
            zero_period_ticks_reg  <= TICK_BITS'(RST_ZERO_PERIOD_TICKS);
            one_period_ticks_reg   <= TICK_BITS'(RST_ONE_PERIOD_TICKS);
            header_mark_ticks_reg  <= TICK_BITS'(RST_HEADER_MARK_TICKS);
            header_total_ticks_reg <= TICK_BITS'(RST_HEADER_TOTAL_TICKS);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MARK_TICKS:         mark_ticks_reg         <= cfg_data;
                REG_ZERO_PERIOD_TICKS:  zero_period_ticks_reg  <= cfg_data;
                REG_ONE_PERIOD_TICKS:   one_period_ticks_reg   <= cfg_data;
                REG_HEADER_MARK_TICKS:  header_mark_ticks_reg  <= cfg_data;
                REG_HEADER_TOTAL_TICKS: header_total_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    irpd_engine #(
        .WORD_BITS (WORD_BITS),
        .TICK_BITS (TICK_BITS)
    ) u_engine (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .step               (s_accept),
        .op                 (s_tuser),
        .address            (s_tdata[BYTE_BITS-1:0]),
        .command_byte       (s_tdata[2*BYTE_BITS-1:BYTE_BITS]),
        .mark_ticks         (mark_ticks_reg),
        .zero_period_ticks  (zero_period_ticks_reg),
        .one_period_ticks   (one_period_ticks_reg),
        .header_mark_ticks  (header_mark_ticks_reg),
        .header_total_ticks (header_total_ticks_reg),
        .result_next        (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_BITS-2){1'b0}}, result_reg.busy_res, result_reg.led};

    a_send_reports_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser == OP_SEND |=> m_tvalid && m_tdata[1])
        else $error("send word did not report busy");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("accepted word produced no result");

    a_send_keeps_led: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser == OP_SEND && $past(s_accept) |=> m_tdata[0] == $past(result_reg.led))
        else $error("send changed led level");

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import irpd_pkg::*;

    typedef logic [9:0] tick_t;

    localparam int HOLD_CYCLES = 40;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RUN_CAP = 300;

    class led_frame_board;
        tick_t mark_t, zero_t, one_t, hdr_mark_t, hdr_total_t;
        logic [15:0] shift_word, second_word;
        int bits_left;
        tick_t phase;
        bit header_pending, second_active, sending, led;
        irpd_result_t led_busy_q[$];
        int errors;

        function new();
            mark_t = tick_t'(RST_MARK_TICKS);
            zero_t = tick_t'(RST_ZERO_PERIOD_TICKS);
            one_t = tick_t'(RST_ONE_PERIOD_TICKS);
            hdr_mark_t = tick_t'(RST_HEADER_MARK_TICKS);
            hdr_total_t = tick_t'(RST_HEADER_TOTAL_TICKS);
            shift_word = '0;
            second_word = '0;
            bits_left = -1;
            phase = 1;
            header_pending = 0;
            second_active = 0;
            sending = 0;
            led = 0;
            errors = 0;
        endfunction

        function void set_reg(irpd_reg_t r, tick_t v);
            case (r)
                REG_MARK_TICKS: mark_t = v;
                REG_ZERO_PERIOD_TICKS: zero_t = v;
                REG_ONE_PERIOD_TICKS: one_t = v;
                REG_HEADER_MARK_TICKS: hdr_mark_t = v;
                REG_HEADER_TOTAL_TICKS: hdr_total_t = v;
                default: ;
            endcase
        endfunction

        function void step_carrier_tick();
            tick_t period;
            if (bits_left > 0) begin
                if (header_pending) begin
                    if (phase <= hdr_mark_t) begin
                        led = !led;
                    end else if (phase <= hdr_total_t) begin
                        led = 0;
                    end else begin
                        phase = 1;
                        header_pending = 0;
                    end
                end
                if (!header_pending) begin
                    period = shift_word[15] ? one_t : zero_t;
                    if (phase <= mark_t) begin
                        led = !led;
                    end else begin
                        led = 0;
                    end
                    if (phase >= period) begin
                        phase = 0;
                        shift_word = shift_word << 1;
                        bits_left--;
                    end
                end
                phase = phase + 1'b1;
            end
            if (bits_left == 0) begin
                if (!second_active) begin
                    shift_word = second_word;
                    bits_left = 16;
                    second_active = 1;
                end else begin
                    if (phase <= mark_t) begin
                        led = !led;
                    end else begin
                        led = 0;
                        phase = 0;
                        bits_left = -1;
                        second_active = 0;
                        sending = 0;
                    end
                    phase = phase + 1'b1;
                end
            end
        endfunction

        function void note_word(irpd_op_t op, logic [7:0] addr, logic [7:0] cmd);
            irpd_result_t r;
            if (op == OP_SEND) begin
                sending = 1;
                phase = 1;
                shift_word = {addr, addr};
                second_word = {cmd, ~cmd};
                bits_left = 16;
                header_pending = 1;
            end else begin
                step_carrier_tick();
            end
            r.led = led;
            r.busy_res = sending;
            led_busy_q.push_back(r);
        endfunction

        function void check_word(logic [M_TDATA_BITS-1:0] d);
            irpd_result_t exp_r, got;
            got = irpd_result_t'(d[1:0]);
            if (led_busy_q.size() == 0) begin
                $error("unexpected word: led=%0b busy_res=%0b", got.led, got.busy_res);
                errors++;
            end else begin
                exp_r = led_busy_q.pop_front();
                if (got.led !== exp_r.led) begin
                    $error("led: expected %0b, got %0b", exp_r.led, got.led);
                    errors++;
                end
                if (got.busy_res !== exp_r.busy_res) begin
                    $error("busy_res: expected %0b, got %0b", exp_r.busy_res, got.busy_res);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return led_busy_q.size();
        endfunction
    endclass

    logic aclk;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    tick_t cfg_data = '0;

    led_frame_board sb = new();
    bit hold_req = 0;
    bit tx_burst = 0;
    int quiet_cycles = 0;

    ir_pulse_distance_transmitter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("[ir_pulse_distance_transmitter] ERROR");
                $finish;
            end
        end
    end

    // result side: random stalls, fast stretches, one long hold-off on request
    initial begin
        int stall;
        int words;
        bit rx_fast;
        words = 0;
        rx_fast = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (words % 50 == 0) begin
                rx_fast = ($urandom_range(0, 2) == 0);
            end
            stall = rx_fast ? 0 : $urandom_range(0, 5);
            if (hold_req) begin
                hold_req = 0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_word(m_tdata);
            words++;
        end
    end

    task automatic push_word(input irpd_op_t op, input logic [BYTE_BITS-1:0] addr,
                             input logic [BYTE_BITS-1:0] cmd);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {cmd, addr};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(op, addr, cmd);
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_word(OP_TICK, 8'($urandom), 8'($urandom));
    endtask

    task automatic write_reg(input irpd_reg_t r, input tick_t v);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(r, v);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        return 8'($urandom);
    endfunction

    task automatic run_phase(input tick_t mk, input tick_t zp, input tick_t op_t,
                             input tick_t hm, input tick_t ht, input int budget,
                             input bit squeeze);
        int used;
        int est;
        int n;
        tick_t longest;
        drain();
        write_reg(REG_MARK_TICKS, mk);
        write_reg(REG_ZERO_PERIOD_TICKS, zp);
        write_reg(REG_ONE_PERIOD_TICKS, op_t);
        write_reg(REG_HEADER_MARK_TICKS, hm);
        write_reg(REG_HEADER_TOTAL_TICKS, ht);
        cfg_valid <= 1'b0;
        tx_burst = ($urandom_range(0, 3) == 0);
        longest = (zp > op_t) ? zp : op_t;
        est = int'(ht) + 1 + 32 * int'(longest) + int'(mk) + 2;
        if (est > RUN_CAP) est = RUN_CAP;
        used = 0;
        while (used < budget) begin
            push_word(OP_SEND, pick_byte(), pick_byte());
            // mostly whole frames plus idle ticks, sometimes a restart mid-frame
            if ($urandom_range(0, 9) < 7) begin
                n = est + $urandom_range(0, 5);
            end else begin
                n = $urandom_range(0, est);
            end
            if (n > budget - used - 1) n = budget - used - 1;
            if (squeeze && used + n + 1 >= budget / 2) begin
                squeeze = 0;
                hold_req = 1;
            end
            push_ticks(n);
            used += n + 1;
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        push_ticks(1);
        push_word(OP_SEND, 8'hFF, 8'h00);
        push_ticks(3);
        push_word(OP_SEND, 8'h00, 8'hFF);
        push_ticks(2);
        push_word(OP_SEND, 8'hA5, 8'h5A);
        push_ticks(2);

        run_phase(1, 1, 1, 1, 1, 80, 0);
        run_phase(1, 1, 2, 1, 3, 100, 1);
        repeat (5) begin
            run_phase(tick_t'($urandom_range(1, 6)), tick_t'($urandom_range(1, 6)),
                      tick_t'($urandom_range(1, 6)), tick_t'($urandom_range(1, 6)),
                      tick_t'($urandom_range(1, 10)), 80, 0);
        end
        run_phase(1023, 1023, 1023, 1023, 1023, 50, 0);
        run_phase(1023, 1, 2, 1, 2, 50, 0);
        run_phase(tick_t'(RST_MARK_TICKS), tick_t'(RST_ZERO_PERIOD_TICKS),
                  tick_t'(RST_ONE_PERIOD_TICKS), tick_t'(RST_HEADER_MARK_TICKS),
                  tick_t'(RST_HEADER_TOTAL_TICKS), 60, 0);

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ir_pulse_distance_transmitter] OK");
        end else begin
            $display("[ir_pulse_distance_transmitter] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/irpd_pkg.sv
rtl/irpd_engine.sv
rtl/ir_pulse_distance_transmitter.sv
dv/tb.sv
